// ===== hdl/efpr_pkg.sv =====
// Shared types, widths and codes for the edge-flag polygon rasteriser.
// No dependencies; every other file of the block but efpr_out_if refers to this package.
package efpr_pkg;

  // Buffer geometry default and pixel word layout
  localparam int BufSize   = 128;
  localparam int WordBits  = 32;
  localparam int WordShift = $clog2(WordBits);
  localparam logic [WordBits-1:0] LeftBit = 32'h8000_0000;
  localparam logic [WordShift-1:0] BitMask = 5'b11111;

  // Fixed-point and coordinate widths
  localparam int FracBits = 16;
  localparam int CoordW   = 16;
  localparam int RelW     = CoordW + 1;          // point minus origin
  localparam int DxW      = RelW + 1;            // difference of two relative points
  localparam int CntW     = RelW;                // |dx|, |dy|, first step index
  localparam int DivW     = CntW + FracBits;     // |dx| << 16
  localparam int StepW    = DivW + 1;            // signed x step
  localparam int AccW     = CntW + StepW + 1;    // k * step
  localparam int KW       = 20;                  // signed step indices
  localparam int IterW    = $clog2(DivW + 1);

  // Configuration port
  localparam int PAddrW = 4;
  localparam int PDataW = 32;
  localparam logic [7:0] ClipReset = 8'd128;

  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_CLIP_RIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [7:0]               clip_right;
  } cfg_t;

  // Commands of the shared add/shift unit
  typedef enum logic [2:0] {
    ALU_NOP      = 3'd0,
    ALU_DIV_LOAD = 3'd1,
    ALU_DIV_STEP = 3'd2,
    ALU_FIX      = 3'd3,
    ALU_MUL_STEP = 3'd4,
    ALU_ACC      = 3'd5
  } alu_cmd_e;

  typedef struct packed {
    alu_cmd_e          cmd;
    logic [DivW-1:0]   dividend;
    logic [CntW-1:0]   divisor;
    logic              neg;
    logic [CntW-1:0]   mult;
  } alu_req_t;

endpackage

// ===== hdl/efpr_in_if.sv =====
// Input channel of the rasteriser: one command transaction per handshake.
// Depends on efpr_pkg for field widths.
interface efpr_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic signed [efpr_pkg::CoordW-1:0] start_x;
  logic signed [efpr_pkg::CoordW-1:0] start_y;
  logic signed [efpr_pkg::CoordW-1:0] end_x;
  logic signed [efpr_pkg::CoordW-1:0] end_y;
  logic [6:0]                       read_row;
  logic [1:0]                       read_word;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, read_row, read_word,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, read_row, read_word,
    output ready
  );
endinterface

// ===== hdl/efpr_out_if.sv =====
// Result channel of the rasteriser: one result transaction per command.
// No dependencies.
interface efpr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        status;

  modport source (
    output valid, read_data, status,
    input  ready
  );
  modport sink (
    input  valid, read_data, status,
    output ready
  );
endinterface

// ===== hdl/efpr_regs.sv =====
// APB-style configuration registers: origin and right clip edge.
// Depends on efpr_pkg (cfg_t, register indexes).
module efpr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efpr_pkg::PAddrW-1:0]   paddr,
  input  logic [efpr_pkg::PDataW-1:0]   pwdata,
  output logic [efpr_pkg::PDataW-1:0]   prdata,
  output logic                          pready,
  output efpr_pkg::cfg_t                cfg_o
);

  efpr_pkg::cfg_t     cfg_q;
  efpr_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = efpr_pkg::reg_idx_e'(paddr[efpr_pkg::PAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.clip_right <= efpr_pkg::ClipReset;
    end else if (wr_en) begin
      case (idx)
        efpr_pkg::REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[efpr_pkg::CoordW-1:0];
        efpr_pkg::REG_ORIGIN_Y:   cfg_q.origin_y   <= pwdata[efpr_pkg::CoordW-1:0];
        efpr_pkg::REG_CLIP_RIGHT: cfg_q.clip_right <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      efpr_pkg::REG_ORIGIN_X:   prdata = {16'b0, cfg_q.origin_x};
      efpr_pkg::REG_ORIGIN_Y:   prdata = {16'b0, cfg_q.origin_y};
      efpr_pkg::REG_CLIP_RIGHT: prdata = {24'b0, cfg_q.clip_right};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== hdl/efpr_arith.sv =====
// Shared add/shift unit: restoring divider, shift-add multiplier and x accumulator,
// all through one adder. Depends on efpr_pkg (alu_req_t, widths).
module efpr_arith (
  input  logic                               clk_i,
  input  efpr_pkg::alu_req_t                 req_i,
  output logic signed [efpr_pkg::AccW-1:0]   acc_o
);

  localparam int AccW  = efpr_pkg::AccW;
  localparam int DivW  = efpr_pkg::DivW;
  localparam int CntW  = efpr_pkg::CntW;
  localparam int StepW = efpr_pkg::StepW;

  logic [DivW-1:0]         dq_q;    // dividend shifting out, quotient shifting in
  logic [CntW-1:0]         rem_q;
  logic [CntW-1:0]         dvs_q;
  logic                    neg_q;
  logic signed [StepW-1:0] step_q;
  logic signed [AccW-1:0]  acc_q;
  logic [CntW-1:0]         mlt_q;

  logic [AccW-1:0] op_a;
  logic [AccW-1:0] op_b;
  logic            cin;
  logic [AccW-1:0] sum;
  logic [AccW-1:0] step_ext;
  logic            qbit;

  assign step_ext = {{(AccW-StepW){step_q[StepW-1]}}, step_q};

  always_comb begin
    op_a = '0;
    op_b = '0;
    cin  = 1'b0;
    case (req_i.cmd)
      efpr_pkg::ALU_DIV_STEP: begin
        op_a = AccW'({rem_q, dq_q[DivW-1]});
        op_b = ~AccW'(dvs_q);
        cin  = 1'b1;
      end
      efpr_pkg::ALU_FIX: begin
        op_b = neg_q ? ~AccW'(dq_q) : AccW'(dq_q);
        cin  = neg_q;
      end
      efpr_pkg::ALU_MUL_STEP: begin
        op_a = AccW'(acc_q) << 1;
        op_b = mlt_q[CntW-1] ? step_ext : '0;
      end
      efpr_pkg::ALU_ACC: begin
        op_a = AccW'(acc_q);
        op_b = step_ext;
      end
      default: ;
    endcase
  end

  assign sum  = op_a + op_b + AccW'(cin);
  assign qbit = ~sum[AccW-1];

  always_ff @(posedge clk_i) begin
    case (req_i.cmd)
      efpr_pkg::ALU_DIV_LOAD: begin
        dq_q  <= req_i.dividend;
        rem_q <= '0;
        dvs_q <= req_i.divisor;
        neg_q <= req_i.neg;
      end
      efpr_pkg::ALU_DIV_STEP: begin
        rem_q <= qbit ? sum[CntW-1:0] : {rem_q[CntW-2:0], dq_q[DivW-1]};
        dq_q  <= {dq_q[DivW-2:0], qbit};
      end
      efpr_pkg::ALU_FIX: begin
        step_q <= $signed(sum[StepW-1:0]);
        acc_q  <= '0;
        mlt_q  <= req_i.mult;
      end
      efpr_pkg::ALU_MUL_STEP: begin
        acc_q <= $signed(sum);
        mlt_q <= {mlt_q[CntW-2:0], 1'b0};
      end
      efpr_pkg::ALU_ACC: acc_q <= $signed(sum);
      default: ;
    endcase
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/efpr_buf.sv =====
// Edge-flag bit buffer: one write port, one read port with registered data.
// Depends on efpr_pkg for the word width and the default depth.
module efpr_buf #(
  parameter int Depth = efpr_pkg::BufSize *
                        ((efpr_pkg::BufSize + efpr_pkg::WordBits - 1) / efpr_pkg::WordBits),
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [efpr_pkg::WordBits-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [efpr_pkg::WordBits-1:0] rdata_o
);

  logic [efpr_pkg::WordBits-1:0] mem [Depth];
  logic [efpr_pkg::WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/edge_flag_polygon_rasterizer_top.sv =====
// Edge-flag polygon rasteriser, top level: sequencer, buffer and shared unit.
// Depends on efpr_pkg, efpr_in_if, efpr_out_if, efpr_regs, efpr_arith, efpr_buf.
//
// Usage
//   in_i  : command transactions (clear buffer, plot one edge, read one word).
//   out_o : exactly one result transaction per command (read data, status).
//   APB   : origin_x, origin_y, clip_right; write only while the block is idle.
// Sequence (BufSize = 128, 512 buffer words)
//   clear : one word zeroed per cycle, Depth words in all.
//   read  : one buffer read, registered data.
//   plot  : setup, then a 33-step serial divide, a 17-step serial multiply for
//           the first row, and one read-modify-write per row plotted (0..BufSize
//           rows); horizontal or fully off-buffer edges finish after the setup.
//   One command is worked on at a time; in_i.ready is high only when idle.
// Reset
//   Asynchronous, active low. Afterwards a clearing pass over all Depth words zeroes
//   the buffer; no command is taken until it ends. Config writes work throughout.
// Back-pressure
//   A finished result waits in the output register while the next command is
//   taken; a second result then waits until the first transaction completes.
module edge_flag_polygon_rasterizer_top #(
  parameter int BufSize = efpr_pkg::BufSize
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  efpr_in_if.sink                       in_i,
  efpr_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efpr_pkg::PAddrW-1:0]   paddr,
  input  logic [efpr_pkg::PDataW-1:0]   pwdata,
  output logic [efpr_pkg::PDataW-1:0]   prdata,
  output logic                          pready
);

  localparam int Wpr   = (BufSize + efpr_pkg::WordBits - 1) / efpr_pkg::WordBits;
  localparam int Depth = BufSize * Wpr;
  localparam int MAW   = $clog2(Depth);
  localparam int PixW  = $clog2(BufSize);
  localparam int LimW  = $clog2(BufSize + 1);
  localparam int RelW  = efpr_pkg::RelW;
  localparam int DxW   = efpr_pkg::DxW;
  localparam int CntW  = efpr_pkg::CntW;
  localparam int KW    = efpr_pkg::KW;
  localparam int AccW  = efpr_pkg::AccW;
  localparam int XsW   = AccW - efpr_pkg::FracBits + 1;
  localparam int IterW = efpr_pkg::IterW;
  localparam logic signed [KW-1:0] BufLast = KW'(BufSize - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SETUP1, S_SETUP2, S_SETUP3, S_DIV, S_FIX,
    S_MUL, S_PREP, S_ROW_RD, S_ROW_WR, S_RD_ISSUE, S_RD_DATA, S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Control registers
  state_e              state_q, state_d;
  logic [MAW-1:0]      clr_q, clr_d;
  logic [IterW-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_data_q, out_data_d;
  logic                out_status_q, out_status_d;

  // Command and working registers (no reset needed)
  efpr_pkg::opcode_e               op_q;
  logic signed [efpr_pkg::CoordW-1:0] sxi_q, syi_q, exi_q, eyi_q;
  logic [6:0]                      rrow_q;
  logic [1:0]                      rword_q;
  logic signed [RelW-1:0]          sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic [CntW-1:0]                 dxm_q, dxm_d, count_q, count_d, kmin_q, kmin_d;
  logic                            dneg_q, dneg_d, up_q, up_d;
  logic signed [KW-1:0]            k_q, k_d, kmax_q, kmax_d;
  logic [PixW-1:0]                 row_q, row_d;
  logic [MAW-1:0]                  addr_q, addr_d;
  logic [31:0]                     mask_q, mask_d;
  logic [31:0]                     res_data_q, res_data_d;
  logic                            res_status_q, res_status_d;

  logic in_acc;
  efpr_pkg::cfg_t     cfg;
  efpr_pkg::alu_req_t alu_req;
  logic signed [AccW-1:0] acc;

  // Buffer port signals
  logic           mem_we, mem_re;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [31:0]    mem_wdata, mem_rdata;

  // ---------------------------------------------------------------------------
  efpr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efpr_arith u_arith (
    .clk_i (clk_i),
    .req_i (alu_req),
    .acc_o (acc)
  );

  efpr_buf #(
    .Depth (Depth),
    .AddrW (MAW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.status    = out_status_q;

  // ---------------------------------------------------------------------------
  // Effective clip edge: 0 acts as 1, anything past the buffer as BufSize
  logic [LimW-1:0] lim;
  always_comb begin
    if (cfg.clip_right == 8'd0) begin
      lim = LimW'(1);
    end else if (32'(cfg.clip_right) > BufSize) begin
      lim = LimW'(BufSize);
    end else begin
      lim = LimW'(cfg.clip_right);
    end
  end

  // Pixel address for the current row: x = floor(acc / 2^16) + sx, clamped
  logic [PixW-1:0]        row_step, row_pix;
  logic signed [XsW-1:0]  xs, xs_hi, lim_s;
  logic [PixW-1:0]        x_pix;
  logic [MAW-1:0]         pix_addr;
  logic [31:0]            pix_mask;

  assign row_step = up_q ? row_q - PixW'(1) : row_q + PixW'(1);
  assign row_pix  = (state_q == S_ROW_WR) ? row_step : row_q;

  always_comb begin
    xs_hi = XsW'($signed(acc[AccW-1:efpr_pkg::FracBits]));
    xs    = xs_hi + XsW'(sx_q);
    lim_s = XsW'($signed({1'b0, lim}));
    if (xs < 0) begin
      x_pix = '0;
    end else if (xs >= lim_s) begin
      x_pix = PixW'(lim - LimW'(1));
    end else begin
      x_pix = PixW'(xs);
    end
    pix_addr = MAW'(32'(row_pix) * Wpr + (32'(x_pix) >> efpr_pkg::WordShift));
    pix_mask = efpr_pkg::LeftBit >> (efpr_pkg::WordShift'(x_pix) & efpr_pkg::BitMask);
  end

  // Read command: address and range check
  logic           rd_ok;
  logic [MAW-1:0] rd_addr;
  assign rd_ok   = (32'(rrow_q) < BufSize) && (32'(rword_q) < Wpr);
  assign rd_addr = MAW'(32'(rrow_q) * Wpr + 32'(rword_q));

  // Buffer ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = mem_rdata ^ mask_q;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_ROW_RD:   mem_re = 1'b1;
      S_ROW_WR:   mem_we = 1'b1;
      S_RD_ISSUE: begin
        mem_re    = rd_ok;
        mem_raddr = rd_addr;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  logic signed [DxW-1:0] dx, dy;
  logic signed [KW-1:0]  sy_k, cm1, kmin_s, kmax0, kmax_c, row0;
  logic                  stat;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    ex_d         = ex_q;
    ey_d         = ey_q;
    dxm_d        = dxm_q;
    dneg_d       = dneg_q;
    count_d      = count_q;
    up_d         = up_q;
    kmin_d       = kmin_q;
    k_d          = k_q;
    kmax_d       = kmax_q;
    row_d        = row_q;
    addr_d       = addr_q;
    mask_d       = mask_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;

    alu_req.cmd      = efpr_pkg::ALU_NOP;
    alu_req.dividend = {dxm_q, efpr_pkg::FracBits'(0)};
    alu_req.divisor  = count_q;
    alu_req.neg      = dneg_q;
    alu_req.mult     = kmin_q;

    // segment setup terms
    dx   = DxW'(ex_q) - DxW'(sx_q);
    dy   = DxW'(ey_q) - DxW'(sy_q);
    sy_k = KW'(sy_q);
    cm1  = KW'($signed({1'b0, count_q})) - KW'(1);
    if (up_q) begin
      kmin_s = (sy_k > BufLast) ? sy_k - BufLast : KW'(0);
      kmax0  = sy_k;
      row0   = (sy_k > BufLast) ? BufLast : sy_k;
    end else begin
      kmin_s = (sy_k < 0) ? -sy_k : KW'(0);
      kmax0  = BufLast - sy_k;
      row0   = (sy_k < 0) ? KW'(0) : sy_k;
    end
    kmax_c = (kmax0 > cm1) ? cm1 : kmax0;
    stat   = (kmin_s > 0) || (kmax0 < cm1);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLEAR: begin
        clr_d = clr_q + MAW'(1);
        if (clr_q == MAW'(Depth - 1)) begin
          clr_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_data_d   = '0;
          res_status_d = 1'b0;
          clr_d        = '0;
          case (efpr_pkg::opcode_e'(in_i.opcode))
            efpr_pkg::OP_CLEAR: state_d = S_CLEAR;
            efpr_pkg::OP_PLOT:  state_d = S_SETUP1;
            efpr_pkg::OP_READ:  state_d = S_RD_ISSUE;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_SETUP1: begin
        sx_d    = RelW'(sxi_q) - RelW'(cfg.origin_x);
        sy_d    = RelW'(syi_q) - RelW'(cfg.origin_y);
        ex_d    = RelW'(exi_q) - RelW'(cfg.origin_x);
        ey_d    = RelW'(eyi_q) - RelW'(cfg.origin_y);
        state_d = S_SETUP2;
      end
      S_SETUP2: begin
        dneg_d  = dx[DxW-1];
        dxm_d   = dx[DxW-1] ? CntW'(-dx) : CntW'(dx);
        up_d    = dy[DxW-1];
        count_d = dy[DxW-1] ? CntW'(-dy) : CntW'(dy);
        state_d = S_SETUP3;
      end
      S_SETUP3: begin
        if (count_q == '0) begin
          // horizontal edge: nothing plotted, status stays clear
          state_d = S_DONE;
        end else begin
          res_status_d = stat;
          if (kmax_c < kmin_s) begin
            state_d = S_DONE;
          end else begin
            alu_req.cmd = efpr_pkg::ALU_DIV_LOAD;
            kmin_d      = CntW'(kmin_s);
            k_d         = kmin_s;
            kmax_d      = kmax_c;
            row_d       = PixW'(row0);
            cnt_d       = '0;
            state_d     = S_DIV;
          end
        end
      end
      S_DIV: begin
        alu_req.cmd = efpr_pkg::ALU_DIV_STEP;
        cnt_d       = cnt_q + IterW'(1);
        if (cnt_q == IterW'(efpr_pkg::DivW - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        alu_req.cmd = efpr_pkg::ALU_FIX;
        cnt_d       = '0;
        state_d     = S_MUL;
      end
      S_MUL: begin
        alu_req.cmd = efpr_pkg::ALU_MUL_STEP;
        cnt_d       = cnt_q + IterW'(1);
        if (cnt_q == IterW'(CntW - 1)) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        addr_d  = pix_addr;
        mask_d  = pix_mask;
        state_d = S_ROW_RD;
      end
      S_ROW_RD: begin
        alu_req.cmd = efpr_pkg::ALU_ACC;
        state_d     = S_ROW_WR;
      end
      S_ROW_WR: begin
        if (k_q == kmax_q) begin
          state_d = S_DONE;
        end else begin
          k_d     = k_q + KW'(1);
          row_d   = row_step;
          addr_d  = pix_addr;
          mask_d  = pix_mask;
          state_d = S_ROW_RD;
        end
      end
      S_RD_ISSUE: state_d = S_RD_DATA;
      S_RD_DATA: begin
        res_data_d = rd_ok ? mem_rdata : '0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      clr_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= efpr_pkg::opcode_e'(in_i.opcode);
      sxi_q   <= in_i.start_x;
      syi_q   <= in_i.start_y;
      exi_q   <= in_i.end_x;
      eyi_q   <= in_i.end_y;
      rrow_q  <= in_i.read_row;
      rword_q <= in_i.read_word;
    end
    sx_q         <= sx_d;
    sy_q         <= sy_d;
    ex_q         <= ex_d;
    ey_q         <= ey_d;
    dxm_q        <= dxm_d;
    dneg_q       <= dneg_d;
    count_q      <= count_d;
    up_q         <= up_d;
    kmin_q       <= kmin_d;
    k_q          <= k_d;
    kmax_q       <= kmax_d;
    row_q        <= row_d;
    addr_q       <= addr_d;
    mask_q       <= mask_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_row_addr_in_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW_RD) |-> (32'(addr_q) < Depth))
    else $error("row address beyond buffer");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW_WR) |-> (k_q <= kmax_q && k_q >= 0))
    else $error("scanline step outside plotted range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion state");

  a_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q != efpr_pkg::OP_READ) |-> (res_data_q == '0))
    else $error("non-read transaction carries data");

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT || state_q == S_CLEAR) |-> (mem_we && mem_wdata == '0))
    else $error("clearing pass not writing zeros");

endmodule

// ===== tb/edge_flag_polygon_rasterizer_top_test.sv =====
// Self-checking testbench for edge_flag_polygon_rasterizer_top: command stimulus,
// its own edge-flag buffer for expected results and an APB register writer.
// Depends on efpr_pkg, efpr_in_if, efpr_out_if and the rasteriser RTL.
`timescale 1ns / 1ps

module edge_flag_polygon_rasterizer_top_test;

  localparam int WordsPerRow   = efpr_pkg::BufSize / efpr_pkg::WordBits;
  localparam logic [1:0] OpUnused = 2'd3;  // no operation, zero result
  localparam int SettleCycles  = 8;        // every command yields a result
  localparam int TailCycles    = 600;      // longer than a clear of the whole buffer
  localparam int HoldCycles    = 1500;     // long receiver hold-off
  localparam int TimeoutNs     = 25_000_000;

  typedef struct packed {
    logic [1:0]                         opcode;
    logic signed [efpr_pkg::CoordW-1:0] start_x;
    logic signed [efpr_pkg::CoordW-1:0] start_y;
    logic signed [efpr_pkg::CoordW-1:0] end_x;
    logic signed [efpr_pkg::CoordW-1:0] end_y;
    logic [6:0]                         read_row;
    logic [1:0]                         read_word;
  } raster_cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } raster_res_t;

  // Clock, reset and APB port
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [efpr_pkg::PAddrW-1:0]  paddr   = '0;
  logic [efpr_pkg::PDataW-1:0]  pwdata  = '0;
  logic [efpr_pkg::PDataW-1:0]  prdata;
  logic                         pready;

  efpr_in_if  cmd_if ();
  efpr_out_if res_if ();

  edge_flag_polygon_rasterizer_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Expected-result side: a private copy of the edge-flag buffer and registers
  logic [efpr_pkg::WordBits-1:0]      flag_mem [efpr_pkg::BufSize][WordsPerRow];
  logic signed [efpr_pkg::CoordW-1:0] cfg_origin_x = '0;
  logic signed [efpr_pkg::CoordW-1:0] cfg_origin_y = '0;
  logic [7:0]                         cfg_clip     = efpr_pkg::ClipReset;

  raster_cmd_t cmd_pending_q[$];   // commands not yet offered to the block
  raster_res_t res_due_q[$];       // results owed by the block, oldest first

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_go     = 1'b0;
  logic rx_hold     = 1'b0;
  int   err_cnt     = 0;

  // Walk one edge a scanline at a time, toggling the flag bit at each row's x.
  // Returns 1 when some rows of the edge fell outside the buffer.
  function automatic logic plot_edge(raster_cmd_t c);
    longint sx, sy, ex, ey, dir, cnt, step, kmin, kmax, k, row, x, lim;
    logic   off_rows;
    sx = longint'(c.start_x) - longint'(cfg_origin_x);
    sy = longint'(c.start_y) - longint'(cfg_origin_y);
    ex = longint'(c.end_x) - longint'(cfg_origin_x);
    ey = longint'(c.end_y) - longint'(cfg_origin_y);
    dir = (ey < sy) ? -1 : 1;
    cnt = (ey < sy) ? (sy - ey) : (ey - sy);
    if (cnt == 0) return 1'b0;   // horizontal: nothing to plot
    // signed 17.16 step, truncating towards zero
    step = ((ex - sx) * 65536) / cnt;
    if (dir > 0) begin
      kmin = (sy < 0) ? -sy : 0;
      kmax = efpr_pkg::BufSize - 1 - sy;
    end else begin
      kmin = (sy > efpr_pkg::BufSize - 1) ? sy - (efpr_pkg::BufSize - 1) : 0;
      kmax = sy;
    end
    if (kmax > cnt - 1) kmax = cnt - 1;
    off_rows = (kmin > 0) || (kmax < cnt - 1);
    // clip edge of 0 behaves as 1, anything past the buffer as its width
    lim = (cfg_clip == 0) ? 1 :
          (cfg_clip > efpr_pkg::BufSize) ? efpr_pkg::BufSize : cfg_clip;
    for (k = kmin; k <= kmax; k++) begin
      row = sy + dir * k;
      x   = ((k * step) >>> efpr_pkg::FracBits) + sx;   // arithmetic shift floors
      if (x < 0) x = 0;
      if (x >= lim) x = lim - 1;
      flag_mem[int'(row)][int'(x >> efpr_pkg::WordShift)] ^=
        efpr_pkg::LeftBit >> (x & efpr_pkg::BitMask);
    end
    return off_rows;
  endfunction

  function automatic raster_res_t rasterise(raster_cmd_t c);
    raster_res_t r;
    r = '0;
    if (c.opcode == efpr_pkg::OP_CLEAR) begin
      foreach (flag_mem[i, j]) flag_mem[i][j] = '0;
    end else if (c.opcode == efpr_pkg::OP_PLOT) begin
      r.status = plot_edge(c);
    end else if (c.opcode == efpr_pkg::OP_READ) begin
      r.read_data = flag_mem[c.read_row][c.read_word];
    end
    return r;
  endfunction

  // Points are given as offsets from the current origin, so most land inside
  // the buffer whatever the origin; wrap-round at the extremes is intended.
  function automatic raster_cmd_t plot_cmd(int x0, int y0, int x1, int y1);
    raster_cmd_t c;
    c = '0;
    c.opcode  = efpr_pkg::OP_PLOT;
    c.start_x = efpr_pkg::CoordW'(cfg_origin_x + x0);
    c.start_y = efpr_pkg::CoordW'(cfg_origin_y + y0);
    c.end_x   = efpr_pkg::CoordW'(cfg_origin_x + x1);
    c.end_y   = efpr_pkg::CoordW'(cfg_origin_y + y1);
    return c;
  endfunction

  function automatic raster_cmd_t read_cmd(int row, int word);
    raster_cmd_t c;
    c = '0;
    c.opcode    = efpr_pkg::OP_READ;
    c.read_row  = 7'(row);
    c.read_word = 2'(word);
    return c;
  endfunction

  // Command driver: one transaction per accepted valid/ready pair. The
  // expected result is worked out at the edge the command is taken.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    raster_cmd_t acc, nxt;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        acc.opcode    = cmd_if.opcode;
        acc.start_x   = cmd_if.start_x;
        acc.start_y   = cmd_if.start_y;
        acc.end_x     = cmd_if.end_x;
        acc.end_y     = cmd_if.end_y;
        acc.read_row  = cmd_if.read_row;
        acc.read_word = cmd_if.read_word;
        res_due_q.push_back(rasterise(acc));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = cmd_pending_q.pop_front();
          cmd_if.opcode    <= nxt.opcode;
          cmd_if.start_x   <= nxt.start_x;
          cmd_if.start_y   <= nxt.start_y;
          cmd_if.end_x     <= nxt.end_x;
          cmd_if.end_y     <= nxt.end_y;
          cmd_if.read_row  <= nxt.read_row;
          cmd_if.read_word <= nxt.read_word;
          cmd_if.valid     <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each transaction is checked against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : res_monitor
    raster_res_t exp_res;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (res_due_q.size() == 0) begin
          $display("%0t: unexpected result: read_data %h status %b",
                   $time, res_if.read_data, res_if.status);
          err_cnt++;
        end else begin
          exp_res = res_due_q.pop_front();
          if (res_if.read_data !== exp_res.read_data) begin
            $display("%0t: read_data mismatch: expected %h actual %h",
                     $time, exp_res.read_data, res_if.read_data);
            err_cnt++;
          end
          if (res_if.status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %b actual %b",
                     $time, exp_res.status, res_if.status);
            err_cnt++;
          end
        end
      end
      res_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off; the sender keeps offering, so the block backs up
  initial begin : rx_hold_off
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // APB write: setup then access phase, taken when pready is high
  task automatic cfg_write(input efpr_pkg::reg_idx_e idx,
                           input logic [efpr_pkg::PDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      efpr_pkg::REG_ORIGIN_X:   cfg_origin_x = val[efpr_pkg::CoordW-1:0];
      efpr_pkg::REG_ORIGIN_Y:   cfg_origin_y = val[efpr_pkg::CoordW-1:0];
      efpr_pkg::REG_CLIP_RIGHT: cfg_clip     = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [efpr_pkg::CoordW-1:0] ox,
                            input logic signed [efpr_pkg::CoordW-1:0] oy,
                            input logic [7:0] clip);
    cfg_write(efpr_pkg::REG_ORIGIN_X,
              {{(efpr_pkg::PDataW-efpr_pkg::CoordW){ox[efpr_pkg::CoordW-1]}}, ox});
    cfg_write(efpr_pkg::REG_ORIGIN_Y,
              {{(efpr_pkg::PDataW-efpr_pkg::CoordW){oy[efpr_pkg::CoordW-1]}}, oy});
    cfg_write(efpr_pkg::REG_CLIP_RIGHT, {24'd0, clip});
  endtask

  // Sampled on the falling edge so that driver updates have settled
  task automatic wait_idle();
    while (cmd_pending_q.size() != 0 || cmd_if.valid || res_due_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly closed contours followed by reads; some open contours, odd clears,
  // stray opcodes and fully random fields as noise.
  task automatic queue_random(input int n_items);
    int made, nv, kind, i, nr;
    int vx[5], vy[5];
    raster_cmd_t c;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        nv = $urandom_range(5, 3);
        for (i = 0; i < nv; i++) begin
          vx[i] = int'($urandom_range(190)) - 30;
          vy[i] = int'($urandom_range(190)) - 30;
        end
        // kinds 60..69 leave the contour open
        for (i = 0; i < ((kind < 60) ? nv : nv - 1); i++)
          cmd_pending_q.push_back(plot_cmd(vx[i], vy[i],
                                           vx[(i + 1) % nv], vy[(i + 1) % nv]));
        made += nv;
        nr = $urandom_range(3, 1);
        for (i = 0; i < nr; i++)
          cmd_pending_q.push_back(read_cmd($urandom_range(127), $urandom_range(3)));
        made += nr;
      end else if (kind < 85) begin
        cmd_pending_q.push_back(read_cmd($urandom_range(127), $urandom_range(3)));
        made++;
      end else if (kind < 88) begin
        c = '0;
        c.opcode = efpr_pkg::OP_CLEAR;
        cmd_pending_q.push_back(c);
        made++;
      end else begin
        c.opcode    = 2'($urandom_range(3));
        c.start_x   = efpr_pkg::CoordW'($urandom);
        c.start_y   = efpr_pkg::CoordW'($urandom);
        c.end_x     = efpr_pkg::CoordW'($urandom);
        c.end_y     = efpr_pkg::CoordW'($urandom);
        c.read_row  = 7'($urandom);
        c.read_word = 2'($urandom);
        cmd_pending_q.push_back(c);
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic signed [efpr_pkg::CoordW-1:0] ox,
                           input logic signed [efpr_pkg::CoordW-1:0] oy,
                           input logic [7:0] clip, input int n_items,
                           input logic with_hold);
    set_config(ox, oy, clip);
    queue_random(n_items);
    if (with_hold) hold_go <= 1'b1;
    wait_idle();
  endtask

  // Main sequence: reset, directed commands, then randomised phases
  initial begin : stimulus
    raster_cmd_t c;
    cmd_if.valid     = 1'b0;
    cmd_if.opcode    = efpr_pkg::OP_CLEAR;
    cmd_if.start_x   = '0;
    cmd_if.start_y   = '0;
    cmd_if.end_x     = '0;
    cmd_if.end_y     = '0;
    cmd_if.read_row  = '0;
    cmd_if.read_word = '0;
    res_if.ready     = 1'b0;
    foreach (flag_mem[i, j]) flag_mem[i][j] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, origin at zero and full clip width
    set_config(16'sd0, 16'sd0, efpr_pkg::ClipReset);
    cmd_pending_q.push_back(read_cmd(0, 0));                // empty after reset
    cmd_pending_q.push_back(plot_cmd(0, 0, 0, 127));        // left column, downwards
    cmd_pending_q.push_back(plot_cmd(127, 127, 127, 0));    // right column, upwards
    cmd_pending_q.push_back(read_cmd(0, 0));
    cmd_pending_q.push_back(read_cmd(126, 3));
    cmd_pending_q.push_back(read_cmd(127, 3));
    cmd_pending_q.push_back(plot_cmd(0, 5, 50, 5));         // horizontal, skipped
    cmd_pending_q.push_back(plot_cmd(10, -10, 20, 20));     // starts above buffer
    cmd_pending_q.push_back(plot_cmd(30, 200, 40, 100));    // starts below, upwards
    cmd_pending_q.push_back(plot_cmd(0, -100, 0, -50));     // wholly off buffer
    cmd_pending_q.push_back(plot_cmd(-50, 10, -10, 30));    // x clamped to left
    cmd_pending_q.push_back(plot_cmd(200, 10, 300, 40));    // x clamped to right
    cmd_pending_q.push_back(plot_cmd(100, 0, 0, 3));        // shallow, negative step
    cmd_pending_q.push_back(plot_cmd(-32768, -32768, 32767, 32767));
    cmd_pending_q.push_back(plot_cmd(32767, 32767, -32768, -32768));
    cmd_pending_q.push_back(read_cmd(64, 1));
    cmd_pending_q.push_back(read_cmd(10, 2));
    cmd_pending_q.push_back(read_cmd(20, 3));
    c = '1;
    c.opcode = OpUnused;                                     // spare opcode
    cmd_pending_q.push_back(c);
    c = '0;
    c.opcode = efpr_pkg::OP_CLEAR;
    cmd_pending_q.push_back(c);
    cmd_pending_q.push_back(read_cmd(64, 1));
    cmd_pending_q.push_back(read_cmd(127, 3));
    wait_idle();

    // Sender idles 30 %, receiver 50 %
    tx_idle_pct = 30;
    rx_idle_pct = 50;
    run_phase(16'sd0, 16'sd0, 8'd128, 100, 1'b0);
    run_phase(-16'sd20, 16'sd10, 8'd64, 100, 1'b0);
    // Swapped, with the long hold-off in the first of these
    tx_idle_pct = 50;
    rx_idle_pct = 30;
    run_phase(16'sd100, -16'sd50, 8'd1, 100, 1'b1);
    run_phase(-16'sd32768, 16'sd32767, 8'd0, 100, 1'b0);
    // No idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(16'sd32767, -16'sd32768, 8'd255, 100, 1'b0);
    run_phase(16'sd5, -16'sd3, 8'd128, 100, 1'b0);

    // Catch any stray result after the last one owed
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("edge_flag_polygon_rasterizer_top_test passed");
    end else begin
      $display("edge_flag_polygon_rasterizer_top_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("edge_flag_polygon_rasterizer_top_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/efpr_pkg.sv
hdl/efpr_in_if.sv
hdl/efpr_out_if.sv
hdl/efpr_regs.sv
hdl/efpr_arith.sv
hdl/efpr_buf.sv
hdl/edge_flag_polygon_rasterizer_top.sv
tb/edge_flag_polygon_rasterizer_top_test.sv
